// ===== hw/rtl/lipm_pkg.sv =====
package lipm_pkg;

    localparam int REQ_W = 2;
    localparam int KEY_W = 32;
    localparam int VAL_W = 16;
    localparam int ST_W  = 2;

    typedef logic [REQ_W-1:0] t_req;
    typedef logic [KEY_W-1:0] t_key;
    typedef logic [VAL_W-1:0] t_val;
    typedef logic [ST_W-1:0]  t_status;

    // request codes
    localparam t_req REQ_CLEAR  = 2'd0;
    localparam t_req REQ_INSERT = 2'd1;
    localparam t_req REQ_LOOKUP = 2'd2;

    // status codes
    localparam t_status ST_DONE = 2'd0;
    localparam t_status ST_HIT  = 2'd1;
    localparam t_status ST_MISS = 2'd2;
    localparam t_status ST_FULL = 2'd3;

    // mixer constants
    localparam t_key MIX_C1 = 32'h7feb352d;
    localparam t_key MIX_C2 = 32'h846ca68b;

    // one slot of the table as held in memory
    typedef struct packed {
        logic used;
        t_key key;
        t_val value;
    } t_slot;

endpackage

// ===== hw/rtl/lipm_req_if.sv =====
interface lipm_req_if;
    logic             valid;
    logic             ready;
    lipm_pkg::t_req   req_type;
    lipm_pkg::t_key   ev_key;
    lipm_pkg::t_val   def_val;

    modport source (output valid, output req_type, output ev_key, output def_val,
                    input ready);
    modport sink   (input valid, input req_type, input ev_key, input def_val,
                    output ready);
endinterface

// ===== hw/rtl/lipm_rsp_if.sv =====
interface lipm_rsp_if;
    logic              valid;
    logic              ready;
    lipm_pkg::t_status status;
    lipm_pkg::t_val    found_index;

    modport source (output valid, output status, output found_index, input ready);
    modport sink   (input valid, input status, input found_index, output ready);
endinterface

// ===== hw/rtl/linear_probe_id_map.sv =====
// Open-addressing map from 32-bit event ids to 16-bit definition indices with linear
// probing. Slots live in one single-port-write, registered-read RAM of TABLE_SLOTS words
// (used flag, key, value). One request is worked at a time: the request port is ready only
// while the engine is idle; a finished response sits in an output register, so a new
// request may be taken while the previous response still waits on its sink. Insert and
// lookup hash the key (two registered 32x32 multiplies, plus a reciprocal remainder when
// TABLE_SLOTS is not a power of two), then probe one slot per registered RAM read; a probe
// chain is at most TABLE_SLOTS slots. Clear walks the RAM one slot per cycle. After reset
// the same wipe pass runs with the request port held not ready. Reserved request code 3
// answers status done without touching the table. A full table drops an insert with
// status full.
module linear_probe_id_map #(
    parameter int TABLE_SLOTS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lipm_req_if.sink          i_req,
    lipm_rsp_if.source        o_rsp
);

    localparam int IDX_W  = $clog2(TABLE_SLOTS);
    localparam int SLOT_W = $bits(lipm_pkg::t_slot);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);

    // engine states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WIPE = 3'd1;   // clear pass, one slot per cycle
    localparam logic [2:0] S_HASH = 3'd2;   // wait for home slot
    localparam logic [2:0] S_RD   = 3'd3;   // RAM read issued
    localparam logic [2:0] S_CHK  = 3'd4;   // slot data back, decide
    localparam logic [2:0] S_RESP = 3'd5;   // hand result to output register

    logic [2:0]          r_state,    n_state;
    logic [IDX_W-1:0]    r_idx,      n_idx;
    logic [IDX_W-1:0]    r_cnt,      n_cnt;
    logic                r_wipe_rsp, n_wipe_rsp;
    lipm_pkg::t_req      r_req,      n_req;
    lipm_pkg::t_key      r_key,      n_key;
    lipm_pkg::t_val      r_val,      n_val;
    lipm_pkg::t_status   r_st,       n_st;
    lipm_pkg::t_val      r_found,    n_found;

    logic                r_out_valid, n_out_valid;
    lipm_pkg::t_status   r_out_status, n_out_status;
    lipm_pkg::t_val      r_out_found,  n_out_found;

    logic                accept;
    logic                hash_done;
    logic [IDX_W-1:0]    hash_home;
    logic                ram_we;
    lipm_pkg::t_slot     ram_wdata;
    lipm_pkg::t_slot     ram_rdata;
    logic [SLOT_W-1:0]   ram_rbits;
    logic [IDX_W-1:0]    idx_next;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    lipm_hash #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && (i_req.req_type == lipm_pkg::REQ_INSERT ||
                             i_req.req_type == lipm_pkg::REQ_LOOKUP)),
        .i_key   (i_req.ev_key),
        .o_done  (hash_done),
        .o_home  (hash_home)
    );

    lipm_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rbits)
    );

    assign ram_rdata = lipm_pkg::t_slot'(ram_rbits);
    assign idx_next  = (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_cnt        = r_cnt;
        n_wipe_rsp   = r_wipe_rsp;
        n_req        = r_req;
        n_key        = r_key;
        n_val        = r_val;
        n_st         = r_st;
        n_found      = r_found;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        ram_we       = 1'b0;
        ram_wdata    = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_req   = i_req.req_type;
                    n_key   = i_req.ev_key;
                    n_val   = i_req.def_val;
                    n_st    = lipm_pkg::ST_DONE;
                    n_found = '0;
                    case (i_req.req_type)
                        lipm_pkg::REQ_CLEAR: begin
                            n_idx      = '0;
                            n_wipe_rsp = 1'b1;
                            n_state    = S_WIPE;
                        end
                        lipm_pkg::REQ_INSERT,
                        lipm_pkg::REQ_LOOKUP: begin
                            n_state = S_HASH;
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_WIPE: begin
                ram_we = 1'b1;
                n_idx  = idx_next;
                if (r_idx == IDX_LAST) begin
                    n_state = r_wipe_rsp ? S_RESP : S_IDLE;
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_idx   = hash_home;
                    n_cnt   = '0;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                // probe step: insert stops on an empty slot or full circle, lookup also on a key match
                n_state = S_RESP;
                if (r_req == lipm_pkg::REQ_INSERT) begin
                    if (!ram_rdata.used) begin
                        ram_we          = 1'b1;
                        ram_wdata.used  = 1'b1;
                        ram_wdata.key   = r_key;
                        ram_wdata.value = r_val;
                        n_st            = lipm_pkg::ST_DONE;
                    end else if (r_cnt == IDX_LAST) begin
                        n_st = lipm_pkg::ST_FULL;
                    end else begin
                        n_idx   = idx_next;
                        n_cnt   = r_cnt + 1'b1;
                        n_state = S_RD;
                    end
                end else begin
                    if (!ram_rdata.used) begin
                        n_st = lipm_pkg::ST_MISS;
                    end else if (ram_rdata.key == r_key) begin
                        n_st    = lipm_pkg::ST_HIT;
                        n_found = ram_rdata.value;
                    end else if (r_cnt == IDX_LAST) begin
                        n_st = lipm_pkg::ST_MISS;
                    end else begin
                        n_idx   = idx_next;
                        n_cnt   = r_cnt + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_RESP: begin
                // wait for the output register to be free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_st;
                    n_out_found  = r_found;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WIPE;
            r_idx       <= '0;
            r_wipe_rsp  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_wipe_rsp  <= n_wipe_rsp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt        <= n_cnt;
        r_req        <= n_req;
        r_key        <= n_key;
        r_val        <= n_val;
        r_st         <= n_st;
        r_found      <= n_found;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.found_index = r_out_found;

endmodule

// ===== hw/rtl/lipm_ram.sv =====
module lipm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/lipm_hash.sv =====
// Home slot: 32-bit mixer, then modulo the table size.
// Power-of-two sizes take the low bits; other sizes take the remainder through a
// reciprocal multiply, then a remainder step.
module lipm_hash #(
    parameter int TABLE_SLOTS = 256
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  lipm_pkg::t_key                 i_key,
    output logic                           o_done,
    output logic [$clog2(TABLE_SLOTS)-1:0] o_home
);

    localparam int IDX_W   = $clog2(TABLE_SLOTS);
    localparam bit IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
    localparam int KEY_W   = lipm_pkg::KEY_W;
    localparam int DIV_SH  = KEY_W + IDX_W;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_MUL1 = 3'd1;
    localparam logic [2:0] PH_MUL2 = 3'd2;
    localparam logic [2:0] PH_FIN  = 3'd3;
    localparam logic [2:0] PH_DIV  = 3'd4;
    localparam logic [2:0] PH_REM  = 3'd5;

    // ceil(2^(KEY_W+IDX_W) / TABLE_SLOTS): gives the exact quotient for any 32-bit value
    localparam logic [KEY_W:0] RECIP = (KEY_W+1)'(((64'd1 << DIV_SH) +
                                       64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS));
    localparam logic [IDX_W-1:0] MOD_N_LO = IDX_W'(TABLE_SLOTS);

    logic [2:0]       r_phase;
    logic             r_done;
    logic [IDX_W-1:0] r_home;
    lipm_pkg::t_key   r_x;
    lipm_pkg::t_key   r_q;

    lipm_pkg::t_key     mul_a;
    lipm_pkg::t_key     mul_b;
    lipm_pkg::t_key     fin_x;
    logic [2*KEY_W:0]   quo_full;
    logic [2*IDX_W-1:0] qn_prod;

    assign mul_a    = r_x * lipm_pkg::MIX_C1;
    assign mul_b    = (r_x ^ (r_x >> 15)) * lipm_pkg::MIX_C2;
    assign fin_x    = r_x ^ (r_x >> 16);
    assign quo_full = r_x * RECIP;
    // only the low index bits of quotient * size matter for the remainder
    assign qn_prod  = r_q[IDX_W-1:0] * MOD_N_LO;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                PH_IDLE: begin
                    if (i_start) begin
                        r_x     <= i_key ^ (i_key >> 16);
                        r_phase <= PH_MUL1;
                    end
                end
                PH_MUL1: begin
                    r_x     <= mul_a;
                    r_phase <= PH_MUL2;
                end
                PH_MUL2: begin
                    r_x     <= mul_b;
                    r_phase <= PH_FIN;
                end
                PH_FIN: begin
                    if (IS_POW2) begin
                        r_home  <= fin_x[IDX_W-1:0];
                        r_done  <= 1'b1;
                        r_phase <= PH_IDLE;
                    end else begin
                        r_x     <= fin_x;
                        r_phase <= PH_DIV;
                    end
                end
                PH_DIV: begin
                    r_q     <= KEY_W'(quo_full >> DIV_SH);
                    r_phase <= PH_REM;
                end
                PH_REM: begin
                    r_home  <= r_x[IDX_W-1:0] - qn_prod[IDX_W-1:0];
                    r_done  <= 1'b1;
                    r_phase <= PH_IDLE;
                end
                default: begin
                    r_phase <= PH_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_home = r_home;

endmodule

// ===== test/tb_linear_probe_id_map.sv =====
`timescale 1ns / 100ps

module tb_linear_probe_id_map;

    localparam int TABLE_SLOTS   = 256;
    localparam int CLK_PERIOD    = 10;
    localparam int MAX_ERR_SHOWN = 10;

    // Request code 3 is reserved: the block answers done and touches nothing.
    localparam lipm_pkg::t_req REQ_UNUSED = 2'd3;

    // Worst request: hashing plus a probe of every slot over a full circle.
    localparam int WORST_REQ_CYCLES = 4 + 2 * TABLE_SLOTS + 1;

    // Receiver hold-off: starts after this many response beats, lasts this long.
    localparam int HOLD_AT_BEAT = 300;
    localparam int HOLD_CYCLES  = 400;

    // Bound on a drain wait: at most two requests in flight (engine plus output
    // register), each a worst-case probe, plus a receiver stall.
    localparam int DRAIN_LIMIT = 4 * (2 * (WORST_REQ_CYCLES + 8)) + HOLD_CYCLES;

    // Quiet cycles after the last response to catch anything spurious.
    localparam int TAIL_CYCLES = WORST_REQ_CYCLES + 16;

    // Slowest correct run is roughly 1500 beats, each at worst a full-circle probe, under
    // 10 ms. Give it five times that.
    localparam longint TIMEOUT_NS = 64'd50_000_000;

    typedef struct packed {
        lipm_pkg::t_status status;
        lipm_pkg::t_val    found;
    } t_rsp;

    // Shadow copy of the table plus the queue of responses still owed.
    class id_map_scoreboard;
        bit             slot_used [TABLE_SLOTS];
        lipm_pkg::t_key slot_key  [TABLE_SLOTS];
        lipm_pkg::t_val slot_val  [TABLE_SLOTS];
        t_rsp owed_rsp [$];
        int   errors;
        int   checked;

        function lipm_pkg::t_key mix_id(lipm_pkg::t_key id);
            lipm_pkg::t_key x;
            x = id;
            x = x ^ (x >> 16);
            x = x * lipm_pkg::MIX_C1;
            x = x ^ (x >> 15);
            x = x * lipm_pkg::MIX_C2;
            x = x ^ (x >> 16);
            return x;
        endfunction

        function int unsigned home_slot(lipm_pkg::t_key id);
            return mix_id(id) % TABLE_SLOTS;
        endfunction

        function void flag_error(string msg);
            errors++;
            if (errors <= MAX_ERR_SHOWN)
                $display("%s", msg);
        endfunction

        // Apply one accepted request to the shadow table, queue its response.
        function void note_request(lipm_pkg::t_req rt, lipm_pkg::t_key id,
                                   lipm_pkg::t_val ix);
            t_rsp        rsp;
            int unsigned idx;
            int          n;
            rsp.status = lipm_pkg::ST_DONE;
            rsp.found  = '0;
            case (rt)
                lipm_pkg::REQ_CLEAR: begin
                    // keys and values stay stale, only the used flags drop
                    foreach (slot_used[i])
                        slot_used[i] = 1'b0;
                end
                lipm_pkg::REQ_INSERT: begin
                    idx        = home_slot(id);
                    rsp.status = lipm_pkg::ST_FULL;
                    for (n = 0; n < TABLE_SLOTS; n++) begin
                        if (!slot_used[idx]) begin
                            slot_used[idx] = 1'b1;
                            slot_key[idx]  = id;
                            slot_val[idx]  = ix;
                            rsp.status     = lipm_pkg::ST_DONE;
                            break;
                        end
                        idx = (idx + 1) % TABLE_SLOTS;
                    end
                end
                lipm_pkg::REQ_LOOKUP: begin
                    idx        = home_slot(id);
                    rsp.status = lipm_pkg::ST_MISS;
                    for (n = 0; n < TABLE_SLOTS; n++) begin
                        if (!slot_used[idx])
                            break;
                        if (slot_key[idx] == id) begin
                            rsp.status = lipm_pkg::ST_HIT;
                            rsp.found  = slot_val[idx];
                            break;
                        end
                        idx = (idx + 1) % TABLE_SLOTS;
                    end
                end
                default: ;
            endcase
            owed_rsp.push_back(rsp);
        endfunction

        function void check_response(lipm_pkg::t_status st, lipm_pkg::t_val fi);
            t_rsp want;
            checked++;
            if (owed_rsp.size() == 0) begin
                flag_error($sformatf("rsp %0d: unexpected beat, status %0d index 0x%h",
                                     checked, st, fi));
                return;
            end
            want = owed_rsp.pop_front();
            if (st !== want.status || fi !== want.found)
                flag_error($sformatf(
                    "rsp %0d: expected status %0d index 0x%h, got status %0d index 0x%h",
                    checked, want.status, want.found, st, fi));
        endfunction

        function int pending();
            return owed_rsp.size();
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Set by the stimulus for stretches where neither side idles.
    bit no_idle = 1'b0;
    int rsp_beats = 0;

    lipm_req_if req_bus ();
    lipm_rsp_if rsp_bus ();

    id_map_scoreboard sb = new();

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    linear_probe_id_map #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    function automatic lipm_pkg::t_val rand_ix();
        return lipm_pkg::t_val'($urandom);
    endfunction

    // Random key whose home slot is the given one; used to build collision
    // clusters and chains that wrap past the last slot.
    function automatic lipm_pkg::t_key find_key_at(int unsigned slot);
        lipm_pkg::t_key id;
        do
            id = $urandom;
        while (sb.home_slot(id) != slot);
        return id;
    endfunction

    // Entered and left on a falling edge. Valid only drops when a gap is drawn,
    // so back-to-back beats keep valid high with one assignment per step.
    task automatic send_req(lipm_pkg::t_req rt, lipm_pkg::t_key id, lipm_pkg::t_val ix);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_bus.valid    <= 1'b1;
        req_bus.req_type <= rt;
        req_bus.ev_key   <= id;
        req_bus.def_val  <= ix;
        do
            @(posedge i_clk);
        while (!req_bus.ready);
        sb.note_request(rt, id, ix);
        @(negedge i_clk);
    endtask

    // Sender pauses until every owed response is in (bounded). Always waits for
    // a falling edge so the next beat's valid is not set in this step.
    task automatic wait_drained();
        int drain;
        drain = 0;
        req_bus.valid <= 1'b0;
        do begin
            @(negedge i_clk);
            drain++;
        end while (sb.pending() > 0 && drain < DRAIN_LIMIT);
    endtask

    // Extremes, duplicates, reserved code, wrap past the last slot, clear.
    task automatic run_directed();
        lipm_pkg::t_key wrap_key;
        wrap_key = find_key_at(TABLE_SLOTS - 1);
        send_req(lipm_pkg::REQ_LOOKUP, '0, '0);                  // empty table: miss
        send_req(lipm_pkg::REQ_INSERT, '0, '0);
        send_req(lipm_pkg::REQ_INSERT, '1, '1);
        send_req(lipm_pkg::REQ_LOOKUP, '0, '1);                  // index field ignored
        send_req(lipm_pkg::REQ_LOOKUP, '1, rand_ix());
        send_req(lipm_pkg::REQ_INSERT, '1, 16'h1234);            // duplicate key
        send_req(lipm_pkg::REQ_LOOKUP, '1, '0);                  // first copy wins
        send_req(REQ_UNUSED, $urandom, rand_ix());
        send_req(REQ_UNUSED, '1, '1);
        repeat (3)
            send_req(lipm_pkg::REQ_INSERT, wrap_key, rand_ix());
        send_req(lipm_pkg::REQ_LOOKUP, wrap_key, '0);
        send_req(lipm_pkg::REQ_LOOKUP, find_key_at(TABLE_SLOTS - 1), '0);  // walks chain
        send_req(lipm_pkg::REQ_CLEAR, $urandom, rand_ix());
        send_req(lipm_pkg::REQ_LOOKUP, '0, '0);                  // stale key, slot not used
        send_req(lipm_pkg::REQ_LOOKUP, wrap_key, '0);
        send_req(lipm_pkg::REQ_INSERT, wrap_key, 16'h00ff);
        send_req(lipm_pkg::REQ_LOOKUP, wrap_key, '0);
    endtask

    // Mixed traffic over a small key pool so hits, duplicate chains and
    // clusters near the top slot (wrapping to slot 0) come up often.
    task automatic run_mixed(int n_items);
        lipm_pkg::t_key pool [24];
        lipm_pkg::t_key id;
        lipm_pkg::t_val ix;
        int             pick;
        int             n;
        foreach (pool[i]) begin
            if (i < 6)
                pool[i] = find_key_at(TABLE_SLOTS - 1 - $urandom_range(0, 2));
            else
                pool[i] = $urandom;
        end
        pool[6] = '0;
        pool[7] = '1;
        send_req(lipm_pkg::REQ_CLEAR, $urandom, rand_ix());
        for (n = 0; n < n_items; n++) begin
            pick = $urandom_range(0, 99);
            id   = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 23)] : $urandom;
            ix   = rand_ix();
            if (pick < 2)
                send_req(lipm_pkg::REQ_CLEAR, id, ix);
            else if (pick < 5)
                send_req(REQ_UNUSED, id, ix);
            else if (pick < 50)
                send_req(lipm_pkg::REQ_INSERT, id, ix);
            else
                send_req(lipm_pkg::REQ_LOOKUP, id, ix);
        end
    endtask

    // Fill every slot, then hit the full-table drop and full-circle miss.
    task automatic run_fill();
        lipm_pkg::t_key stored [TABLE_SLOTS];
        lipm_pkg::t_key dropped;
        int             n;
        send_req(lipm_pkg::REQ_CLEAR, $urandom, rand_ix());
        for (n = 0; n < TABLE_SLOTS; n++) begin
            stored[n] = $urandom;
            send_req(lipm_pkg::REQ_INSERT, stored[n], rand_ix());
        end
        for (n = 0; n < 4; n++) begin
            dropped = $urandom;
            send_req(lipm_pkg::REQ_INSERT, dropped, rand_ix());
        end
        send_req(lipm_pkg::REQ_LOOKUP, dropped, '0);             // drop left no trace
        for (n = 0; n < 12; n++) begin
            if (n % 2)
                send_req(lipm_pkg::REQ_LOOKUP, stored[$urandom_range(0, TABLE_SLOTS - 1)],
                         '0);
            else
                send_req(lipm_pkg::REQ_LOOKUP, $urandom, '0);
        end
        send_req(lipm_pkg::REQ_CLEAR, $urandom, rand_ix());
    endtask

    // Response side: random stall per beat, one long hold-off once the beat
    // count reaches HOLD_AT_BEAT so the output register and the engine fill
    // and the request port backs up.
    initial begin
        int stall;
        rsp_bus.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (rsp_beats == HOLD_AT_BEAT)
                stall = HOLD_CYCLES;
            else
                stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            do
                @(posedge i_clk);
            while (!rsp_bus.valid);
            sb.check_response(rsp_bus.status, rsp_bus.found_index);
            rsp_beats++;
            @(negedge i_clk);
        end
    end

    // Stimulus: reset, directed beats, then ten phases of mixed traffic, phases 2 and 7 fill.
    // Two phases run with no idling; odd phases end with a full drain.
    initial begin
        int phase;
        req_bus.valid    = 1'b0;
        req_bus.req_type = lipm_pkg::REQ_CLEAR;
        req_bus.ev_key   = '0;
        req_bus.def_val  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // the wipe pass after reset keeps ready low; send_req waits it out
        run_directed();
        wait_drained();
        for (phase = 0; phase < 10; phase++) begin
            no_idle = (phase == 3 || phase == 7);
            if (phase == 2 || phase == 7)
                run_fill();
            else
                run_mixed(110);
            if (phase % 2 == 1)
                wait_drained();
        end
        no_idle = 1'b0;
        wait_drained();
        if (sb.pending() > 0)
            sb.flag_error($sformatf("%0d responses never arrived", sb.pending()));
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("linear_probe_id_map: match");
        end else begin
            $display("linear_probe_id_map: mismatch");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("linear_probe_id_map: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/lipm_pkg.sv
hw/rtl/lipm_req_if.sv
hw/rtl/lipm_rsp_if.sv
hw/rtl/lipm_ram.sv
hw/rtl/lipm_hash.sv
hw/rtl/linear_probe_id_map.sv
test/tb_linear_probe_id_map.sv
